// ===== sv/gcli_pkg.sv =====
// gcli_pkg: shared types, constants and register indexes for the grid cell index unit
// no dependencies

package gcli_pkg;

  localparam int MAX_DIMS_DEF  = 3;
  localparam int CELL_BITS_DEF = 16;

  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 31;
  localparam int CELL_W   = 16;
  localparam int RADIX_W  = 16;
  localparam int LINEAR_W = 48;
  localparam int TAG_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_DIMS = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIM0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIM1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIM2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DIM0  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DIM1  = 3'd6;

  // one dimension's quotient and its out-of-range mark
  typedef struct packed {
    logic              flag;
    logic [CELL_W-1:0] idx;
  } cell_res_t;

endpackage

// ===== sv/gcli_cell_div.sv =====
// gcli_cell_div: pipelined restoring divider, one quotient bit per stage, with clamp/saturate
// depends on gcli_pkg

module gcli_cell_div import gcli_pkg::*; #(
  parameter int CELL_BITS = CELL_BITS_DEF
) (
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] coord,
  input  logic signed [COORD_W-1:0] origin,
  input  logic        [SIZE_W-1:0]  divisor,
  output cell_res_t                 res
);

  localparam int W = COORD_W + CELL_BITS + 1;

  logic signed [COORD_W:0]  diff_r;
  logic [COORD_W-1:0]       rem_r [0:CELL_BITS];
  logic [CELL_BITS-1:0]     q_r   [0:CELL_BITS];
  logic                     neg_r [0:CELL_BITS];
  logic                     sat_r [0:CELL_BITS];
  logic [W-1:0]             dvs_ext;

  assign dvs_ext = {{(W-SIZE_W){1'b0}}, divisor};

  // exact 33-bit difference
  always_ff @(posedge clk) begin
    diff_r <= {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
  end

  // saturation check: quotient reaches 2^CELL_BITS
  always_ff @(posedge clk) begin
    rem_r[0] <= diff_r[COORD_W-1:0];
    neg_r[0] <= diff_r[COORD_W];
    sat_r[0] <= !diff_r[COORD_W] &&
                ({{(W-COORD_W){1'b0}}, diff_r[COORD_W-1:0]} >= (dvs_ext << CELL_BITS));
    q_r[0]   <= '0;
  end

  for (genvar i = 0; i < CELL_BITS; i++) begin : g_step
    logic [W-1:0] sh;
    logic [W-1:0] rem_ext;
    logic [W-1:0] trial;
    logic         ge;
    assign sh      = dvs_ext << (CELL_BITS - 1 - i);
    assign rem_ext = {{(W-COORD_W){1'b0}}, rem_r[i]};
    assign trial   = rem_ext - sh;
    assign ge      = rem_ext >= sh;
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? trial[COORD_W-1:0] : rem_r[i];
      q_r[i+1]   <= {q_r[i][CELL_BITS-2:0], ge};
      neg_r[i+1] <= neg_r[i];
      sat_r[i+1] <= sat_r[i];
    end
  end

  always_comb begin
    res.flag = neg_r[CELL_BITS] | sat_r[CELL_BITS];
    if (neg_r[CELL_BITS]) begin
      res.idx = '0;
    end else if (sat_r[CELL_BITS]) begin
      res.idx = CELL_W'({CELL_BITS{1'b1}});
    end else begin
      res.idx = CELL_W'(q_r[CELL_BITS]);
    end
  end

endmodule

// ===== sv/gcli_combine.sv =====
// gcli_combine: masks inactive dimensions and forms the mixed-radix linear id in three stages
// depends on gcli_pkg

module gcli_combine import gcli_pkg::*; (
  input  logic                clk,
  input  cell_res_t           res_i [NUM_DIMS],
  input  logic [1:0]          dims,
  input  logic [RADIX_W-1:0]  radix0,
  input  logic [RADIX_W-1:0]  radix1,
  output logic [CELL_W-1:0]   cell_x,
  output logic [CELL_W-1:0]   cell_y,
  output logic [CELL_W-1:0]   cell_z,
  output logic [LINEAR_W-1:0] linear,
  output logic                flag
);

  logic [CELL_W-1:0]   c_a_r [NUM_DIMS];
  logic [CELL_W-1:0]   c_b_r [NUM_DIMS];
  logic [CELL_W-1:0]   c_c_r [NUM_DIMS];
  logic                f_a_r, f_b_r, f_c_r;
  logic [31:0]         p1_r, p01_r;
  logic [LINEAR_W-1:0] p2_r, s1_r, lin_r;
  logic                act_y, act_z;
  logic [CELL_W-1:0]   my, mz;

  assign act_y = dims >= 2'd2;
  assign act_z = dims >= 2'd3;
  assign my    = act_y ? res_i[1].idx : '0;
  assign mz    = act_z ? res_i[2].idx : '0;

  always_ff @(posedge clk) begin
    c_a_r[0] <= res_i[0].idx;
    c_a_r[1] <= my;
    c_a_r[2] <= mz;
    f_a_r    <= res_i[0].flag | (act_y & res_i[1].flag) | (act_z & res_i[2].flag);
    p1_r     <= 32'(my) * 32'(radix0);
    p01_r    <= 32'(radix0) * 32'(radix1);
  end

  always_ff @(posedge clk) begin
    c_b_r <= c_a_r;
    f_b_r <= f_a_r;
    p2_r  <= LINEAR_W'(c_a_r[2]) * LINEAR_W'(p01_r);
    s1_r  <= LINEAR_W'(c_a_r[0]) + LINEAR_W'(p1_r);
  end

  always_ff @(posedge clk) begin
    c_c_r <= c_b_r;
    f_c_r <= f_b_r;
    lin_r <= s1_r + p2_r;
  end

  assign cell_x = c_c_r[0];
  assign cell_y = c_c_r[1];
  assign cell_z = c_c_r[2];
  assign linear = lin_r;
  assign flag   = f_c_r;

endmodule

// ===== sv/grid_cell_linear_index_unit.sv =====
// grid_cell_linear_index_unit: top level, config registers, per-dimension dividers, combine
// depends on gcli_pkg, gcli_cell_div, gcli_combine

// usage
//   input channel: drive start with coord_x/y/z and point_number; an item is taken
//   at each rising edge where start is high and busy is low. busy is never raised,
//   so a new point may enter every clock.
//   result channel: out_valid pulses for one cycle with point_tag, cells, linear id
//   and range_flag. the receiver cannot stall and need not: results leave at the
//   same rate as items enter.
//   pipeline: CELL_BITS + 5 register stages (21 at the default), the first loaded at
//   the accepting edge: one diff stage, one saturation stage, one stage per
//   quotient bit, then three stages of mixed-radix multiply and add. out_valid
//   rises together with the result from the last stage.
//   throughput: one item per cycle.
//   config port: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. write only while no items are in flight.
//   reset (rst_n low, synchronous) loads the register defaults and drops all
//   in-flight valid bits; payload stages are not reset.
module grid_cell_linear_index_unit import gcli_pkg::*; #(
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int CELL_BITS = CELL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [COORD_W-1:0]    in_coord_z,
  input  logic [TAG_W-1:0]      in_point_number,
  output logic                  out_valid,
  output logic [TAG_W-1:0]      out_point_tag,
  output logic [CELL_W-1:0]     out_cell_x,
  output logic [CELL_W-1:0]     out_cell_y,
  output logic [CELL_W-1:0]     out_cell_z,
  output logic [LINEAR_W-1:0]   out_linear_cell,
  output logic                  out_range_flag,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAT = CELL_BITS + 5;

  // config registers
  logic [1:0]         active_dims_r;
  logic [SIZE_W-1:0]  cell_size_r;
  logic [COORD_W-1:0] min_r [NUM_DIMS];
  logic [RADIX_W-1:0] cells_dim0_r, cells_dim1_r;

  logic [SIZE_W-1:0]  divisor;
  logic [1:0]         dims_eff;
  logic               accept;
  logic [LAT-1:0]     vld_r;
  logic [TAG_W-1:0]   tag_r [LAT];
  logic [COORD_W-1:0] coords [NUM_DIMS];
  cell_res_t          res [NUM_DIMS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= 2'd3;
      cell_size_r   <= SIZE_W'(65536);
      min_r[0]      <= '0;
      min_r[1]      <= '0;
      min_r[2]      <= '0;
      cells_dim0_r  <= RADIX_W'(1);
      cells_dim1_r  <= RADIX_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_DIMS: active_dims_r <= cfg_data[1:0];
        REG_CELL_SIZE:   cell_size_r   <= cfg_data[SIZE_W-1:0];
        REG_MIN_DIM0:    min_r[0]      <= cfg_data;
        REG_MIN_DIM1:    min_r[1]      <= cfg_data;
        REG_MIN_DIM2:    min_r[2]      <= cfg_data;
        REG_CELLS_DIM0:  cells_dim0_r  <= cfg_data[RADIX_W-1:0];
        REG_CELLS_DIM1:  cells_dim1_r  <= cfg_data[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // zero cell size acts as the smallest step
  assign divisor = (cell_size_r == '0) ? SIZE_W'(1) : cell_size_r;

  // clamp dimension count into 1..MAX_DIMS
  always_comb begin
    if (active_dims_r == 2'd0) begin
      dims_eff = 2'd1;
    end else if (active_dims_r > 2'(MAX_DIMS)) begin
      dims_eff = 2'(MAX_DIMS);
    end else begin
      dims_eff = active_dims_r;
    end
  end

  assign coords[0] = in_coord_x;
  assign coords[1] = in_coord_y;
  assign coords[2] = in_coord_z;

  // one divider per built dimension; dimensions beyond MAX_DIMS stay at zero
  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
    if (d < MAX_DIMS) begin : g_div
      gcli_cell_div #(.CELL_BITS(CELL_BITS)) u_div (
        .clk     (clk),
        .coord   (coords[d]),
        .origin  (min_r[d]),
        .divisor (divisor),
        .res     (res[d])
      );
    end else begin : g_none
      assign res[d] = '0;
    end
  end

  gcli_combine u_comb (
    .clk    (clk),
    .res_i  (res),
    .dims   (dims_eff),
    .radix0 (cells_dim0_r),
    .radix1 (cells_dim1_r),
    .cell_x (out_cell_x),
    .cell_y (out_cell_y),
    .cell_z (out_cell_z),
    .linear (out_linear_cell),
    .flag   (out_range_flag)
  );

  // valid bits and point tag travel alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_point_number;
    for (int i = 1; i < LAT; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_point_tag = tag_r[LAT-1];

endmodule
